### design/bde_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the block delta encoder
// used by bde_emit and block_delta_encoder, depends on nothing
package bde_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_STATE_BYTES = 65536;
    localparam int DEF_BLOCK_BYTES     = 64;
    localparam int RESET_STATE_BYTES   = 65536;

    // delta format constants
    localparam int HEADER_BYTES = 16;
    localparam int INDEX_BYTES  = 4;

    // field widths of the result word
    localparam int KIND_W    = 3;
    localparam int WORD_W    = 64;
    localparam int CHANGED_W = 11;
    localparam int PAYLOAD_W = 17;
    localparam int RES_W     = WORD_W + CHANGED_W + PAYLOAD_W + 1;
    localparam int TDATA_W   = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - RES_W;

    // configuration port
    localparam int CFG_W           = 17;
    localparam int APB_DATA_W      = 32;
    localparam int PADDR_W         = 3;
    localparam int REG_STATE_BYTES = 0;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_BLOCK_SIZE   = 3'd0,
        KIND_BLOCK_COUNT  = 3'd1,
        KIND_TAIL_LENGTH  = 3'd2,
        KIND_BLOCK_INDEX  = 3'd3,
        KIND_BLOCK_DATA   = 3'd4,
        KIND_TAIL_BYTE    = 3'd5,
        KIND_RAW_BYTE     = 3'd6,
        KIND_TRAILER      = 3'd7
    } kind_t;

    // what one input byte asks the emitter to send
    typedef struct packed {
        logic hdr;       // three header words
        logic one_byte;  // tail or raw byte word
        logic raw;       // byte word is a raw byte
        logic blk;       // block index and data words
        logic bank;      // buffer bank holding the block
        logic trl;       // trailer word
        logic key;       // keyframe flag for the trailer
    } emit_ctl_t;

endpackage

### design/block_delta_encoder.sv
`timescale 1ns / 1ps
// Block delta encoder, top level; depends on bde_pkg and bde_emit.
//
// Snapshot bytes come in on s_axis (one byte per word, address order). Each
// snapshot of state_bytes bytes is compared in blocks of BLOCK_BYTES against
// the previous snapshot kept in an on-chip store. Results leave on m_axis:
// kind in tuser, word/changed/payload/keyframe in tdata, tlast on the trailer.
// With a valid previous snapshot the stream is header, index plus data words
// of each changed block, tail bytes, trailer; otherwise raw bytes and trailer.
// A byte passes the compare stage, the emitter request register and the output
// register before its first word shows on m_axis. Throughput: one byte per
// cycle unless the size computation runs or the emitter or m_axis holds it; a
// changed block holds the emitter for its index and data words; body bytes
// that cause no word never wait on it. A stalled m_axis holds its word in the
// output register; the request stage and then s_axis_tready back up behind it.
// Writing state_bytes over APB (register 0) clears the previous-snapshot mark
// and starts the block count and tail computation (reciprocal multiply, then
// multiply back and subtract), during which no byte is taken.
// After reset the size is the smaller of 65536 and MAX_STATE_BYTES, the store
// content is unknown and the first snapshot goes out raw.
module block_delta_encoder #(
    parameter int MAX_STATE_BYTES = bde_pkg::DEF_MAX_STATE_BYTES,
    parameter int BLOCK_BYTES     = bde_pkg::DEF_BLOCK_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // snapshot byte stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // state_byte
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bde_pkg::TDATA_W-1:0]   m_axis_tdata,  // word, changed_blocks, payload_length, keyframe, pad
    output logic [bde_pkg::KIND_W-1:0]    m_axis_tuser,  // kind
    output logic                          m_axis_tlast,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bde_pkg::PADDR_W-1:0]   paddr,
    input  logic [bde_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bde_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int NW     = $clog2(MAX_STATE_BYTES + 1);
    localparam int AW     = $clog2(MAX_STATE_BYTES);
    localparam int RW     = $clog2(BLOCK_BYTES);
    localparam int CW     = $clog2(MAX_STATE_BYTES / BLOCK_BYTES + 1);
    localparam int PW     = $clog2(bde_pkg::HEADER_BYTES + (MAX_STATE_BYTES / BLOCK_BYTES)
                                   * (bde_pkg::INDEX_BYTES + BLOCK_BYTES) + BLOCK_BYTES + 1);
    localparam int KW     = (PW > NW) ? PW : NW;
    localparam int WORDS  = (BLOCK_BYTES + 7) / 8;
    localparam int WIW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_W = (BLOCK_BYTES - 1) / 8;
    localparam int LAST_L = (BLOCK_BYTES - 1) % 8;
    localparam int STEP   = bde_pkg::INDEX_BYTES + BLOCK_BYTES;
    localparam int CNTW   = 2;
    localparam int QS     = NW + RW;
    localparam int MW     = NW + 1;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << QS) + 64'(BLOCK_BYTES) - 64'd1)
                                          / 64'(BLOCK_BYTES));
    localparam int RESET_N = (bde_pkg::RESET_STATE_BYTES > MAX_STATE_BYTES)
                             ? MAX_STATE_BYTES : bde_pkg::RESET_STATE_BYTES;
    localparam int RESET_BLOCKS = RESET_N / BLOCK_BYTES;
    localparam int RESET_TAIL   = RESET_N % BLOCK_BYTES;

    // previous snapshot store
    logic [7:0]       prev_mem [MAX_STATE_BYTES];
    logic [7:0]       rd_reg;

    // configuration and size
    logic             cfg_we;
    logic [bde_pkg::CFG_W-1:0] cfg_value;
    logic [NW-1:0]    n_clamp;
    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    blocks_reg;
    logic [RW-1:0]    tail_reg;

    // block count by reciprocal multiply
    logic [CNTW-1:0]  cnt_reg;
    logic [NW+MW-1:0] quo_prod;
    logic [NW-1:0]    quo_cur;
    logic [NW-1:0]    body_cur;
    logic [NW-1:0]    rest_cur;
    logic             busy;

    // byte position tracking
    logic [NW-1:0]    pos_reg;
    logic [NW-1:0]    pos_inc;
    logic [2:0]       lane_reg;
    logic [WIW-1:0]   wrd_reg;
    logic [NW-1:0]    bidx_reg;
    logic             delta_reg;
    logic             prev_valid_reg;
    logic             s_acc;
    logic             first_cur;
    logic             last_cur;
    logic             delta_cur;
    logic [2:0]       lane_cur;
    logic [WIW-1:0]   wrd_cur;
    logic [NW-1:0]    bidx_cur;
    logic             in_body_cur;
    logic             blk_end_cur;

    // compare stage
    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic             s1_delta_reg;
    logic             s1_in_body_reg;
    logic             s1_blk_end_reg;
    logic             s1_bstart_reg;
    logic [2:0]       s1_lane_reg;
    logic [WIW-1:0]   s1_wrd_reg;
    logic [NW-1:0]    s1_bidx_reg;
    logic             differs_reg;
    logic [CW-1:0]    changed_reg;
    logic [PW-1:0]    payload_reg;
    logic             bank_reg;
    logic             differs_acc;
    logic             emit_blk;
    logic [CW-1:0]    changed_now;
    logic [PW-1:0]    payload_now;
    bde_pkg::emit_ctl_t desc_ctl;
    logic             desc_any;
    logic             load_valid;
    logic             load_ready;
    logic             s1_adv;
    logic             buf_we;

    // APB port
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite
                       && (paddr[bde_pkg::PADDR_W-1:2] == 1'(bde_pkg::REG_STATE_BYTES));
    assign cfg_value = pwdata[bde_pkg::CFG_W-1:0];
    assign prdata    = (paddr[bde_pkg::PADDR_W-1:2] == 1'(bde_pkg::REG_STATE_BYTES))
                       ? bde_pkg::APB_DATA_W'(n_reg) : '0;

    // size clamp
    always_comb
    begin
        priority if (cfg_value == '0)
        begin
            n_clamp = NW'(1);
        end
        else if (32'(cfg_value) > 32'(MAX_STATE_BYTES))
        begin
            n_clamp = NW'(MAX_STATE_BYTES);
        end
        else
        begin
            n_clamp = NW'(cfg_value);
        end
    end

    // block count first, then the tail from the registered block count
    assign busy     = (cnt_reg != '0);
    assign quo_prod = (NW+MW)'(n_reg) * (NW+MW)'(RECIP);
    assign quo_cur  = NW'(quo_prod[NW+MW-1:QS]);
    assign body_cur = blocks_reg * NW'(BLOCK_BYTES);
    assign rest_cur = n_reg - body_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= NW'(RESET_N);
            blocks_reg <= NW'(RESET_BLOCKS);
            tail_reg   <= RW'(RESET_TAIL);
            cnt_reg    <= '0;
        end
        else if (cfg_we)
        begin
            n_reg   <= n_clamp;
            cnt_reg <= CNTW'(2);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(2))
            begin
                blocks_reg <= quo_cur;
            end
            else
            begin
                tail_reg <= rest_cur[RW-1:0];
            end
        end
    end

    // position of the incoming byte
    assign s_acc       = s_axis_tvalid && s_axis_tready;
    assign first_cur   = (pos_reg == '0);
    assign pos_inc     = pos_reg + NW'(1);
    assign last_cur    = (pos_inc == n_reg);
    assign delta_cur   = first_cur ? prev_valid_reg : delta_reg;
    assign lane_cur    = first_cur ? 3'd0 : lane_reg;
    assign wrd_cur     = first_cur ? '0 : wrd_reg;
    assign bidx_cur    = first_cur ? '0 : bidx_reg;
    assign in_body_cur = (bidx_cur < blocks_reg);
    assign blk_end_cur = in_body_cur && (wrd_cur == WIW'(LAST_W)) && (lane_cur == 3'(LAST_L));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            lane_reg       <= '0;
            wrd_reg        <= '0;
            bidx_reg       <= '0;
            delta_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            pos_reg        <= '0;
            delta_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else if (s_acc)
        begin
            pos_reg   <= last_cur ? '0 : pos_inc;
            delta_reg <= delta_cur;
            if (last_cur)
            begin
                prev_valid_reg <= 1'b1;
            end
            if (blk_end_cur)
            begin
                lane_reg <= '0;
                wrd_reg  <= '0;
                bidx_reg <= bidx_cur + NW'(1);
            end
            else
            begin
                lane_reg <= lane_cur + 3'd1;
                wrd_reg  <= (lane_cur == 3'd7) ? wrd_cur + WIW'(1) : wrd_cur;
                bidx_reg <= bidx_cur;
            end
        end
    end

    // store access, read-first so a repeated address sees the old byte
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            rd_reg                <= prev_mem[pos_reg[AW-1:0]];
            prev_mem[pos_reg[AW-1:0]] <= s_axis_tdata;
        end
    end

    // compare stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_byte_reg    <= s_axis_tdata;
            s1_first_reg   <= first_cur;
            s1_last_reg    <= last_cur;
            s1_delta_reg   <= delta_cur;
            s1_in_body_reg <= in_body_cur;
            s1_blk_end_reg <= blk_end_cur;
            s1_bstart_reg  <= (lane_cur == 3'd0) && (wrd_cur == '0);
            s1_lane_reg    <= lane_cur;
            s1_wrd_reg     <= wrd_cur;
            s1_bidx_reg    <= bidx_cur;
        end
    end

    // block difference and running totals
    assign differs_acc = (s1_bstart_reg ? 1'b0 : differs_reg) || (rd_reg != s1_byte_reg);
    assign emit_blk    = s1_delta_reg && s1_blk_end_reg && differs_acc;
    assign changed_now = (s1_first_reg ? '0 : changed_reg) + CW'(emit_blk);
    assign payload_now = (s1_first_reg ? PW'(bde_pkg::HEADER_BYTES) + PW'(tail_reg) : payload_reg)
                         + (emit_blk ? PW'(STEP) : '0);

    // request for the emitter
    always_comb
    begin
        desc_ctl.hdr      = s1_first_reg && s1_delta_reg;
        desc_ctl.one_byte = !s1_delta_reg || !s1_in_body_reg;
        desc_ctl.raw      = !s1_delta_reg;
        desc_ctl.blk      = emit_blk;
        desc_ctl.bank     = bank_reg;
        desc_ctl.trl      = s1_last_reg;
        desc_ctl.key      = !s1_delta_reg || (KW'(payload_now) >= KW'(n_reg));
    end

    assign desc_any   = desc_ctl.hdr || desc_ctl.one_byte || desc_ctl.blk || desc_ctl.trl;
    assign load_valid = s1_valid_reg && desc_any;
    assign s1_adv     = s1_valid_reg && (!desc_any || load_ready);
    assign buf_we     = s1_adv && s1_delta_reg && s1_in_body_reg;

    assign s_axis_tready = !busy && (!s1_valid_reg || s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            differs_reg <= 1'b0;
            changed_reg <= '0;
            payload_reg <= '0;
            bank_reg    <= 1'b0;
        end
        else if (s1_adv)
        begin
            differs_reg <= differs_acc;
            changed_reg <= changed_now;
            payload_reg <= payload_now;
            if (emit_blk)
            begin
                bank_reg <= !bank_reg;
            end
        end
    end

    bde_emit #(
        .MAX_STATE_BYTES (MAX_STATE_BYTES),
        .BLOCK_BYTES     (BLOCK_BYTES)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (load_valid),
        .load_ready    (load_ready),
        .load_ctl      (desc_ctl),
        .load_byte     (s1_byte_reg),
        .load_bidx     (s1_bidx_reg),
        .load_changed  (s1_delta_reg ? changed_now : '0),
        .load_payload  (s1_delta_reg ? payload_now : '0),
        .hdr_blocks    (blocks_reg),
        .hdr_tail      (tail_reg),
        .buf_we        (buf_we),
        .buf_bank      (bank_reg),
        .buf_wrd       (s1_wrd_reg),
        .buf_lane      (s1_lane_reg),
        .buf_byte      (s1_byte_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // position stays inside the snapshot once the size is settled
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (pos_reg < n_reg))
        else $error("byte position outside the snapshot");

    // a held request keeps its byte and stays in the compare stage
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (load_valid && !load_ready) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("compare stage lost a stalled byte");

    // finishing a snapshot makes the store usable for the next one
    a_prev_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && last_cur && !cfg_we) |=> (prev_valid_reg && (pos_reg == '0)))
        else $error("snapshot end did not mark the store valid");

endmodule

### design/bde_emit.sv
`timescale 1ns / 1ps
// result sequencer: holds the double-banked block buffer and turns one
// byte's request into its words on the output stream; depends on bde_pkg
module bde_emit #(
    parameter int MAX_STATE_BYTES = bde_pkg::DEF_MAX_STATE_BYTES,
    parameter int BLOCK_BYTES     = bde_pkg::DEF_BLOCK_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request from the compare stage
    input  logic                          load_valid,
    output logic                          load_ready,
    input  bde_pkg::emit_ctl_t            load_ctl,
    input  logic [7:0]                    load_byte,
    input  logic [$clog2(MAX_STATE_BYTES+1)-1:0] load_bidx,
    input  logic [$clog2(MAX_STATE_BYTES/BLOCK_BYTES+1)-1:0] load_changed,
    input  logic [$clog2(bde_pkg::HEADER_BYTES + (MAX_STATE_BYTES/BLOCK_BYTES)
                  * (bde_pkg::INDEX_BYTES+BLOCK_BYTES) + BLOCK_BYTES + 1)-1:0] load_payload,
    // header values of the current size
    input  logic [$clog2(MAX_STATE_BYTES+1)-1:0] hdr_blocks,
    input  logic [$clog2(BLOCK_BYTES)-1:0] hdr_tail,
    // block buffer write port
    input  logic                          buf_we,
    input  logic                          buf_bank,
    input  logic [(((BLOCK_BYTES+7)/8) > 1 ? $clog2((BLOCK_BYTES+7)/8) : 1)-1:0] buf_wrd,
    input  logic [2:0]                    buf_lane,
    input  logic [7:0]                    buf_byte,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bde_pkg::TDATA_W-1:0]   m_axis_tdata,  // word, changed_blocks, payload_length, keyframe, pad
    output logic [bde_pkg::KIND_W-1:0]    m_axis_tuser,  // kind
    output logic                          m_axis_tlast
);

    localparam int NW     = $clog2(MAX_STATE_BYTES + 1);
    localparam int RW     = $clog2(BLOCK_BYTES);
    localparam int CW     = $clog2(MAX_STATE_BYTES / BLOCK_BYTES + 1);
    localparam int PW     = $clog2(bde_pkg::HEADER_BYTES + (MAX_STATE_BYTES / BLOCK_BYTES)
                                   * (bde_pkg::INDEX_BYTES + BLOCK_BYTES) + BLOCK_BYTES + 1);
    localparam int WORDS  = (BLOCK_BYTES + 7) / 8;
    localparam int WIW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_W = (BLOCK_BYTES - 1) / 8;
    localparam int LAST_L = (BLOCK_BYTES - 1) % 8;
    localparam logic [bde_pkg::WORD_W-1:0] LAST_MASK = (LAST_L == 7) ? {bde_pkg::WORD_W{1'b1}}
        : ((bde_pkg::WORD_W'(1) << (8 * (LAST_L + 1))) - bde_pkg::WORD_W'(1));

    typedef struct packed {
        logic hdr0;
        logic hdr1;
        logic hdr2;
        logic idx;
        logic data;
        logic one_byte;
        logic trl;
    } pend_t;

    // block buffer, two banks of packed words
    logic [bde_pkg::WORD_W-1:0] bb_mem [2][WORDS];

    logic                 cur_valid_reg;
    pend_t                pend_reg;
    pend_t                pend_after;
    logic [WIW-1:0]       dw_reg;
    logic [WIW-1:0]       dw_next;
    logic [7:0]           cur_byte_reg;
    logic                 cur_raw_reg;
    logic                 cur_bank_reg;
    logic                 cur_key_reg;
    logic [NW-1:0]        cur_bidx_reg;
    logic [CW-1:0]        cur_changed_reg;
    logic [PW-1:0]        cur_payload_reg;

    logic                 out_free;
    logic                 fire;
    logic                 take;
    logic [bde_pkg::WORD_W-1:0] data_word;

    bde_pkg::kind_t              sel_kind;
    logic [bde_pkg::WORD_W-1:0]    sel_word;
    logic [bde_pkg::CHANGED_W-1:0] sel_changed;
    logic [bde_pkg::PAYLOAD_W-1:0] sel_payload;
    logic                          sel_key;
    logic                          sel_last;

    bde_pkg::kind_t              kind_reg;
    logic [bde_pkg::WORD_W-1:0]    word_reg;
    logic [bde_pkg::CHANGED_W-1:0] changed_reg;
    logic [bde_pkg::PAYLOAD_W-1:0] payload_reg;
    logic                          key_reg;
    logic                          last_reg;
    logic                          valid_reg;

    // buffer write, one byte lane at a time
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            bb_mem[buf_bank][buf_wrd][buf_lane*8 +: 8] <= buf_byte;
        end
    end

    // word read, upper lanes of a short last word read as zero
    always_comb
    begin
        data_word = bb_mem[cur_bank_reg][dw_reg];
        if (dw_reg == WIW'(LAST_W))
        begin
            data_word = data_word & LAST_MASK;
        end
    end

    assign out_free   = !valid_reg || m_axis_tready;
    assign fire       = cur_valid_reg && out_free;
    assign load_ready = !cur_valid_reg || (fire && (pend_after == '0));
    assign take       = load_valid && load_ready;

    // pick the next word in stream order
    always_comb
    begin
        pend_after  = pend_reg;
        dw_next     = dw_reg;
        sel_kind    = bde_pkg::KIND_TRAILER;
        sel_word    = '0;
        sel_changed = '0;
        sel_payload = '0;
        sel_key     = 1'b0;
        sel_last    = 1'b0;
        priority if (pend_reg.hdr0)
        begin
            sel_kind        = bde_pkg::KIND_BLOCK_SIZE;
            sel_word        = bde_pkg::WORD_W'(BLOCK_BYTES);
            pend_after.hdr0 = 1'b0;
        end
        else if (pend_reg.hdr1)
        begin
            sel_kind        = bde_pkg::KIND_BLOCK_COUNT;
            sel_word        = bde_pkg::WORD_W'(hdr_blocks);
            pend_after.hdr1 = 1'b0;
        end
        else if (pend_reg.hdr2)
        begin
            sel_kind        = bde_pkg::KIND_TAIL_LENGTH;
            sel_word        = bde_pkg::WORD_W'(hdr_tail);
            pend_after.hdr2 = 1'b0;
        end
        else if (pend_reg.idx)
        begin
            sel_kind       = bde_pkg::KIND_BLOCK_INDEX;
            sel_word       = bde_pkg::WORD_W'(cur_bidx_reg);
            pend_after.idx = 1'b0;
        end
        else if (pend_reg.data)
        begin
            sel_kind = bde_pkg::KIND_BLOCK_DATA;
            sel_word = data_word;
            if (dw_reg == WIW'(LAST_W))
            begin
                pend_after.data = 1'b0;
            end
            else
            begin
                dw_next = dw_reg + WIW'(1);
            end
        end
        else if (pend_reg.one_byte)
        begin
            sel_kind            = cur_raw_reg ? bde_pkg::KIND_RAW_BYTE : bde_pkg::KIND_TAIL_BYTE;
            sel_word            = bde_pkg::WORD_W'(cur_byte_reg);
            pend_after.one_byte = 1'b0;
        end
        else
        begin
            sel_changed    = (bde_pkg::CHANGED_W)'(cur_changed_reg);
            sel_payload    = (bde_pkg::PAYLOAD_W)'(cur_payload_reg);
            sel_key        = cur_key_reg;
            sel_last       = 1'b1;
            pend_after.trl = 1'b0;
        end
    end

    // current request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pend_reg      <= '0;
            dw_reg        <= '0;
        end
        else if (take)
        begin
            cur_valid_reg <= 1'b1;
            pend_reg      <= '{hdr0: load_ctl.hdr, hdr1: load_ctl.hdr, hdr2: load_ctl.hdr,
                               idx: load_ctl.blk, data: load_ctl.blk,
                               one_byte: load_ctl.one_byte, trl: load_ctl.trl};
            dw_reg        <= '0;
        end
        else if (fire)
        begin
            cur_valid_reg <= (pend_after != '0);
            pend_reg      <= pend_after;
            dw_reg        <= dw_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_byte_reg    <= load_byte;
            cur_raw_reg     <= load_ctl.raw;
            cur_bank_reg    <= load_ctl.bank;
            cur_key_reg     <= load_ctl.key;
            cur_bidx_reg    <= load_bidx;
            cur_changed_reg <= load_changed;
            cur_payload_reg <= load_payload;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg    <= sel_kind;
            word_reg    <= sel_word;
            changed_reg <= sel_changed;
            payload_reg <= sel_payload;
            key_reg     <= sel_key;
            last_reg    <= sel_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{bde_pkg::PAD_W{1'b0}}, key_reg, payload_reg, changed_reg, word_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

    // a live request always has a word left
    a_cur_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (pend_reg != '0))
        else $error("emitter holds a request with nothing pending");

    // a new request only replaces one that is finishing
    a_take_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cur_valid_reg) |-> (fire && (pend_after == '0)))
        else $error("emitter request overwritten before done");

    // the frame end marker goes with the trailer only
    a_last_is_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == bde_pkg::KIND_TRAILER))
        else $error("tlast on a word that is not a trailer");

endmodule
